// ===== src/b3cp_pkg.sv =====
// ---------------------------------------------------------------------------
// b3cp_pkg
// Types and constants shared by the 3D box corner projector.
// ---------------------------------------------------------------------------
package b3cp_pkg;

  // angles in radians Q3.12
  localparam logic signed [15:0] PI_Q12      = 16'sd12868;
  localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
  localparam logic signed [15:0] TWO_PI_Q12  = 16'sd25736;

  // rotation CORDIC, sine and cosine in Q.24
  localparam int CORDIC_STEPS = 20;
  localparam logic signed [26:0] CORDIC_GAIN_Q24 = 27'sd10188014;
  localparam logic [24:0] ATAN_Q24 [CORDIC_STEPS] = '{
    25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331, 25'd1047214,
    25'd524117, 25'd262123, 25'd131069, 25'd65536, 25'd32768,
    25'd16384, 25'd8192, 25'd4096, 25'd2048, 25'd1024,
    25'd512, 25'd256, 25'd128, 25'd64, 25'd32
  };

  // camera frame coordinates are clamped to +-2^40 (meters Q.16)
  localparam logic [40:0] CAM_LIM = 41'd1 << 40;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTRE_X   = 3'd2,
    REG_CENTRE_Y   = 3'd3,
    REG_NEAR_LIMIT = 3'd4,
    REG_FAR_LIMIT  = 3'd5
  } reg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEPTH = 2'd1,
    ST_NEAR  = 2'd2
  } status_e;

  typedef struct packed {
    logic [19:0] focal_x;
    logic [19:0] focal_y;
    logic [19:0] centre_x;
    logic [19:0] centre_y;
    logic [15:0] near_limit;
    logic [15:0] far_limit;
  } cfg_t;

  typedef logic signed [41:0] pos_t;  // camera frame position, meters Q.16
  typedef logic signed [26:0] dep_t;  // corner depth, meters Q.16

  // one detection's corner geometry, handed to the corner sequencer
  typedef struct packed {
    logic        rej_depth;
    logic        rej_near;
    pos_t [3:0]  xc;      // per footprint corner
    dep_t [3:0]  zc;      // per footprint corner
    pos_t        ycam;    // object centre row coordinate
    logic [22:0] half_h;
  } geom_t;

endpackage

// ===== src/b3cp_div.sv =====
// ---------------------------------------------------------------------------
// b3cp_div
// Pipelined restoring divider, one quotient bit per stage. Flags overflow
// when the quotient does not fit in QB bits. Sideband travels alongside.
// ---------------------------------------------------------------------------
module b3cp_div #(
  parameter int NW = 48,
  parameter int DW = 20,
  parameter int QB = 41,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vi,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  input  logic [SW-1:0] side,
  output logic          vo,
  output logic [QB-1:0] q,
  output logic          ovf,
  output logic [SW-1:0] side_o
);

  localparam int HW = NW - QB;
  localparam int CW = (HW > DW) ? HW : DW;

  logic          v    [0:QB];
  logic [DW-1:0] rem  [0:QB];
  logic [QB-1:0] nq   [0:QB];
  logic [DW-1:0] dv   [0:QB];
  logic          ov   [0:QB];
  logic [SW-1:0] sd   [0:QB];

  // entry stage: overflow check and remainder seed
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(n[NW-1:QB]);
      nq[0]  <= n[QB-1:0];
      dv[0]  <= d;
      ov[0]  <= CW'(n[NW-1:QB]) >= CW'(d);
      sd[0]  <= side;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] sub;
    logic        ge;

    assign t   = {rem[s], nq[s][QB-1]};
    assign sub = t - {1'b0, dv[s]};
    assign ge  = t >= {1'b0, dv[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? sub[DW-1:0] : t[DW-1:0];
        nq[s+1]  <= {nq[s][QB-2:0], ge};
        dv[s+1]  <= dv[s];
        ov[s+1]  <= ov[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign vo     = v[QB];
  assign q      = nq[QB];
  assign ovf    = ov[QB];
  assign side_o = sd[QB];

endmodule

// ===== src/b3cp_front.sv =====
// ---------------------------------------------------------------------------
// b3cp_front
// Per-detection pipeline: depth check, unprojection of the bottom centre,
// CORDIC sine/cosine, yaw rotation and near-corner check.
// ---------------------------------------------------------------------------
module b3cp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    box_left,
  input  logic signed [15:0]    box_top,
  input  logic [15:0]           box_span_x,
  input  logic [15:0]           box_span_y,
  input  logic [15:0]           depth,
  input  logic [15:0]           obj_height,
  input  logic [15:0]           obj_width,
  input  logic [15:0]           obj_length,
  input  logic signed [14:0]    heading,
  input  b3cp_pkg::cfg_t        cfg,
  output logic                  out_valid,
  output b3cp_pkg::geom_t       out_geom,
  input  logic                  take
);

  localparam int NS = b3cp_pkg::CORDIC_STEPS;

  // ox negative on corners 0 and 3, oz negative on corners 0 and 1
  localparam logic [3:0] OX_NEG = 4'b1001;
  localparam logic [3:0] OZ_NEG = 4'b0011;

  typedef struct packed {
    logic               rej;
    logic               neg;
    logic [15:0]        d;
    logic [15:0]        h;
    logic [15:0]        w;
    logic [15:0]        l;
    logic signed [40:0] prod_x;
    logic signed [40:0] prod_y;
  } cord_side_t;

  typedef struct packed {
    logic               rej;
    logic               sx;
    logic signed [26:0] sin_v;
    logic signed [26:0] cos_v;
    logic [15:0]        d;
    logic [15:0]        h;
    logic [15:0]        w;
    logic [15:0]        l;
  } div_side_t;

  function automatic logic signed [27:0] rnd24(input logic signed [51:0] s);
    logic [51:0] mag;
    logic [51:0] sum;
    logic [27:0] qq;
    mag = s[51] ? 52'(-s) : 52'(s);
    sum = mag + (52'd1 << 23);
    qq  = sum[51:24];
    return s[51] ? -$signed(qq) : $signed(qq);
  endfunction

  logic fe;
  logic k_v;

  assign fe       = !k_v || take;
  assign in_ready = fe;

  // -------- stage A: offsets from principal point, yaw wrap, depth check
  logic               a_v;
  logic signed [23:0] a_du, a_dv;
  logic signed [15:0] a_ang;
  logic [15:0]        a_d, a_h, a_w, a_l;
  logic               a_rej;

  logic signed [23:0] sum_u, sum_v, du_c, dv_c;
  logic signed [15:0] hd16, ang_w;

  always_comb begin
    sum_u = ($signed({{8{box_left[15]}}, box_left}) <<< 1) + $signed({8'b0, box_span_x});
    sum_v = $signed({{8{box_top[15]}}, box_top}) + $signed({8'b0, box_span_y});
    du_c  = (sum_u <<< 3) - $signed({4'b0, cfg.centre_x});
    dv_c  = (sum_v <<< 4) - $signed({4'b0, cfg.centre_y});
    hd16  = {heading[14], heading};
    if (hd16 > b3cp_pkg::PI_Q12) begin
      ang_w = hd16 - b3cp_pkg::TWO_PI_Q12;
    end else if (hd16 < -b3cp_pkg::PI_Q12) begin
      ang_w = hd16 + b3cp_pkg::TWO_PI_Q12;
    end else begin
      ang_w = hd16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (fe) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      a_du  <= du_c;
      a_dv  <= dv_c;
      a_ang <= ang_w;
      a_d   <= depth;
      a_h   <= obj_height;
      a_w   <= obj_width;
      a_l   <= obj_length;
      a_rej <= (depth <= cfg.near_limit) || (depth > cfg.far_limit);
    end
  end

  // -------- stage B (CORDIC seed): offset times depth, yaw fold by pi
  logic               c_v   [0:NS];
  logic signed [26:0] c_x   [0:NS];
  logic signed [26:0] c_y   [0:NS];
  logic signed [27:0] c_z   [0:NS];
  cord_side_t         c_sd  [0:NS];

  logic signed [15:0] ang_f;
  logic               fold;

  always_comb begin
    if (a_ang > b3cp_pkg::HALF_PI_Q12) begin
      ang_f = a_ang - b3cp_pkg::PI_Q12;
      fold  = 1'b1;
    end else if (a_ang < -b3cp_pkg::HALF_PI_Q12) begin
      ang_f = a_ang + b3cp_pkg::PI_Q12;
      fold  = 1'b1;
    end else begin
      ang_f = a_ang;
      fold  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (fe) begin
      c_v[0] <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      c_x[0]         <= b3cp_pkg::CORDIC_GAIN_Q24;
      c_y[0]         <= '0;
      c_z[0]         <= {{12{ang_f[15]}}, ang_f} <<< 12;
      c_sd[0].rej    <= a_rej;
      c_sd[0].neg    <= fold;
      c_sd[0].d      <= a_d;
      c_sd[0].h      <= a_h;
      c_sd[0].w      <= a_w;
      c_sd[0].l      <= a_l;
      c_sd[0].prod_x <= a_du * $signed({1'b0, a_d});
      c_sd[0].prod_y <= a_dv * $signed({1'b0, a_d});
    end
  end

  // -------- CORDIC rotation, one step per stage
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[i+1] <= 1'b0;
      end else if (fe) begin
        c_v[i+1] <= c_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (fe) begin
        if (c_z[i] >= 0) begin
          c_x[i+1] <= c_x[i] - (c_y[i] >>> i);
          c_y[i+1] <= c_y[i] + (c_x[i] >>> i);
          c_z[i+1] <= c_z[i] - $signed({3'b0, b3cp_pkg::ATAN_Q24[i]});
        end else begin
          c_x[i+1] <= c_x[i] + (c_y[i] >>> i);
          c_y[i+1] <= c_y[i] - (c_x[i] >>> i);
          c_z[i+1] <= c_z[i] + $signed({3'b0, b3cp_pkg::ATAN_Q24[i]});
        end
        c_sd[i+1] <= c_sd[i];
      end
    end
  end

  // -------- stage E: unfold sine/cosine, divider numerators with rounding
  logic        e_v;
  logic [47:0] e_nx, e_ny;
  logic        e_sy;
  div_side_t   e_sd;

  logic [19:0] fxd, fyd;
  logic [40:0] px_abs, py_abs;
  cord_side_t  cs;

  always_comb begin
    cs     = c_sd[NS];
    fxd    = (cfg.focal_x == '0) ? 20'd1 : cfg.focal_x;
    fyd    = (cfg.focal_y == '0) ? 20'd1 : cfg.focal_y;
    px_abs = cs.prod_x[40] ? 41'(-cs.prod_x) : 41'(cs.prod_x);
    py_abs = cs.prod_y[40] ? 41'(-cs.prod_y) : 41'(cs.prod_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (fe) begin
      e_v <= c_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      e_nx       <= {px_abs[39:0], 8'b0} + 48'(fxd >> 1);
      e_ny       <= {py_abs[39:0], 8'b0} + 48'(fyd >> 1);
      e_sy       <= cs.prod_y[40];
      e_sd.rej   <= cs.rej;
      e_sd.sx    <= cs.prod_x[40];
      e_sd.sin_v <= cs.neg ? -c_y[NS] : c_y[NS];
      e_sd.cos_v <= cs.neg ? -c_x[NS] : c_x[NS];
      e_sd.d     <= cs.d;
      e_sd.h     <= cs.h;
      e_sd.w     <= cs.w;
      e_sd.l     <= cs.l;
    end
  end

  // -------- dividers for the camera frame coordinates
  logic        dx_v, dy_v;
  logic [40:0] qx, qy;
  logic        ovx, ovy;
  div_side_t   dx_sd;
  logic        dy_sy;

  b3cp_div #(.NW(48), .DW(20), .QB(41), .SW($bits(div_side_t))) u_div_x (
    .clk(clk), .rst(rst), .en(fe), .vi(e_v), .n(e_nx), .d(fxd), .side(e_sd),
    .vo(dx_v), .q(qx), .ovf(ovx), .side_o(dx_sd)
  );

  b3cp_div #(.NW(48), .DW(20), .QB(41), .SW(1)) u_div_y (
    .clk(clk), .rst(rst), .en(fe), .vi(e_v), .n(e_ny), .d(fyd), .side(e_sy),
    .vo(dy_v), .q(qy), .ovf(ovy), .side_o(dy_sy)
  );

  // -------- stage F: clamp and sign the camera coordinates
  logic                 f_v, f_rej;
  b3cp_pkg::pos_t       f_xcam, f_ycam;
  logic [23:0]          f_zcam;
  logic [22:0]          f_hh, f_hw, f_hl;
  logic signed [26:0]   f_sin, f_cos;
  logic [40:0]          limx, limy;
  b3cp_pkg::pos_t       ycam_c;

  always_comb begin
    limx   = (ovx || (qx > b3cp_pkg::CAM_LIM)) ? b3cp_pkg::CAM_LIM : qx;
    limy   = (ovy || (qy > b3cp_pkg::CAM_LIM)) ? b3cp_pkg::CAM_LIM : qy;
    ycam_c = dy_sy ? -$signed({1'b0, limy}) : $signed({1'b0, limy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (fe) begin
      f_v <= dx_v && dy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      f_rej  <= dx_sd.rej;
      f_xcam <= dx_sd.sx ? -$signed({1'b0, limx}) : $signed({1'b0, limx});
      f_ycam <= ycam_c - $signed({19'b0, dx_sd.h, 7'b0});
      f_zcam <= {dx_sd.d, 8'b0};
      f_hh   <= {dx_sd.h, 7'b0};
      f_hw   <= {dx_sd.w, 7'b0};
      f_hl   <= {dx_sd.l, 7'b0};
      f_sin  <= dx_sd.sin_v;
      f_cos  <= dx_sd.cos_v;
    end
  end

  // -------- stage G: half sizes times sine and cosine
  logic               g_v, g_rej;
  b3cp_pkg::pos_t     g_xcam, g_ycam;
  logic [23:0]        g_zcam;
  logic [22:0]        g_hh;
  logic signed [50:0] g_hwc, g_hws, g_hlc, g_hls;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (fe) begin
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      g_rej  <= f_rej;
      g_xcam <= f_xcam;
      g_ycam <= f_ycam;
      g_zcam <= f_zcam;
      g_hh   <= f_hh;
      g_hwc  <= $signed({1'b0, f_hw}) * f_cos;
      g_hws  <= $signed({1'b0, f_hw}) * f_sin;
      g_hlc  <= $signed({1'b0, f_hl}) * f_cos;
      g_hls  <= $signed({1'b0, f_hl}) * f_sin;
    end
  end

  // -------- stage H: rotated offsets before scaling, per footprint corner
  logic               h_v, h_rej;
  b3cp_pkg::pos_t     h_xcam, h_ycam;
  logic [23:0]        h_zcam;
  logic [22:0]        h_hh;
  logic signed [51:0] h_xs [4];
  logic signed [51:0] h_zs [4];
  logic signed [51:0] xs_c [4];
  logic signed [51:0] zs_c [4];

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      xs_c[q] = (OX_NEG[q] ? -52'(g_hlc) : 52'(g_hlc))
              + (OZ_NEG[q] ? -52'(g_hws) : 52'(g_hws));
      zs_c[q] = (OZ_NEG[q] ? -52'(g_hwc) : 52'(g_hwc))
              - (OX_NEG[q] ? -52'(g_hls) : 52'(g_hls));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (fe) begin
      h_v <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      h_rej  <= g_rej;
      h_xcam <= g_xcam;
      h_ycam <= g_ycam;
      h_zcam <= g_zcam;
      h_hh   <= g_hh;
      h_xs   <= xs_c;
      h_zs   <= zs_c;
    end
  end

  // -------- stage I: round back to Q.16
  logic               i_v, i_rej;
  b3cp_pkg::pos_t     i_xcam, i_ycam;
  logic [23:0]        i_zcam;
  logic [22:0]        i_hh;
  logic signed [27:0] i_xr [4];
  logic signed [27:0] i_zr [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (fe) begin
      i_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      i_rej  <= h_rej;
      i_xcam <= h_xcam;
      i_ycam <= h_ycam;
      i_zcam <= h_zcam;
      i_hh   <= h_hh;
      for (int q = 0; q < 4; q++) begin
        i_xr[q] <= rnd24(h_xs[q]);
        i_zr[q] <= rnd24(h_zs[q]);
      end
    end
  end

  // -------- stage J: translate to the object centre
  logic                 j_v, j_rej;
  b3cp_pkg::pos_t       j_ycam;
  logic [22:0]          j_hh;
  b3cp_pkg::pos_t [3:0] j_xc;
  b3cp_pkg::dep_t [3:0] j_zc;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_v <= 1'b0;
    end else if (fe) begin
      j_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      j_rej  <= i_rej;
      j_ycam <= i_ycam;
      j_hh   <= i_hh;
      for (int q = 0; q < 4; q++) begin
        j_xc[q] <= i_xcam + 42'(i_xr[q]);
        j_zc[q] <= $signed({3'b0, i_zcam}) + 27'(i_zr[q]);
      end
    end
  end

  // -------- stage K: near-corner check, hand-off register
  logic                 near_any;
  logic signed [26:0]   near16;

  always_comb begin
    near16   = $signed({3'b0, cfg.near_limit, 8'b0});
    near_any = 1'b0;
    for (int q = 0; q < 4; q++) begin
      near_any = near_any | (j_zc[q] <= near16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (fe) begin
      k_v <= j_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      out_geom.rej_depth <= j_rej;
      out_geom.rej_near  <= near_any;
      out_geom.xc        <= j_xc;
      out_geom.zc        <= j_zc;
      out_geom.ycam      <= j_ycam;
      out_geom.half_h    <= j_hh;
    end
  end

  assign out_valid = k_v;

endmodule

// ===== src/box3d_corner_projector_top.sv =====
// ---------------------------------------------------------------------------
// box3d_corner_projector_top
// Projects the eight corners of a 3D bounding box to image pixels.
// ---------------------------------------------------------------------------
// Usage:
//   One detection arrives per beat on the s_t* channel. Each detection gives
//   either eight corner beats (corner_index 0..7, status projected, tlast on
//   corner 7) or a single reject beat (status in tuser, zero coordinates,
//   tlast set) on the m_t* channel.
//   Registers are written through cfg_we/cfg_index/cfg_data while idle.
// Pipeline:
//   Unprojection runs through its own pipeline (two 41-bit pipelined dividers,
//   a 20-stage CORDIC, rotation), then per-corner projection runs through two
//   16-bit pipelined dividers. The corner sequencer issues one corner per
//   cycle while m_tready lets it, so a projected detection gives eight beats
//   and a rejected one a single beat; that sequencer sets the sustained rate.
// Reset and stall:
//   rst empties all pipelines and loads the default intrinsics and limits.
//   When m_tready is low, the pipelines hold as they fill up behind the waiting beat; nothing is dropped.
// ---------------------------------------------------------------------------
module box3d_corner_projector_top (
  input  logic         clk,
  input  logic         rst,
  // detection beats
  input  logic         s_tvalid,
  output logic         s_tready,
  // box_left, box_top, box_span_x, box_span_y, depth, obj_height,
  // obj_width, obj_length, heading (15 bits), one pad bit
  input  logic [143:0] s_tdata,
  // result beats
  output logic         m_tvalid,
  input  logic         m_tready,
  // corner_index (3), corner_x (16), corner_y (16), five pad bits
  output logic [39:0]  m_tdata,
  // status (2)
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  // configuration writes
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [19:0]  cfg_data
);

  // -------- configuration registers
  b3cp_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x    <= 20'd70477;
      cfg.focal_y    <= 20'd125172;
      cfg.centre_x   <= 20'd77460;
      cfg.centre_y   <= 20'd77079;
      cfg.near_limit <= 16'd26;
      cfg.far_limit  <= 16'd38400;
    end else if (cfg_we) begin
      unique case (cfg_index)
        b3cp_pkg::REG_FOCAL_X:    cfg.focal_x    <= cfg_data;
        b3cp_pkg::REG_FOCAL_Y:    cfg.focal_y    <= cfg_data;
        b3cp_pkg::REG_CENTRE_X:   cfg.centre_x   <= cfg_data;
        b3cp_pkg::REG_CENTRE_Y:   cfg.centre_y   <= cfg_data;
        b3cp_pkg::REG_NEAR_LIMIT: cfg.near_limit <= cfg_data[15:0];
        b3cp_pkg::REG_FAR_LIMIT:  cfg.far_limit  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // -------- per-detection front end
  logic            f_valid;
  logic            take;
  b3cp_pkg::geom_t f_geom;

  b3cp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .box_left   ($signed(s_tdata[15:0])),
    .box_top    ($signed(s_tdata[31:16])),
    .box_span_x (s_tdata[47:32]),
    .box_span_y (s_tdata[63:48]),
    .depth      (s_tdata[79:64]),
    .obj_height (s_tdata[95:80]),
    .obj_width  (s_tdata[111:96]),
    .obj_length (s_tdata[127:112]),
    .heading    ($signed(s_tdata[142:128])),
    .cfg        (cfg),
    .out_valid  (f_valid),
    .out_geom   (f_geom),
    .take       (take)
  );

  // -------- corner sequencer
  logic            be;
  logic            o_v;
  logic            sq_v;
  logic [2:0]      sq_k;
  b3cp_pkg::geom_t sq_g;

  b3cp_pkg::status_e   sq_st;
  logic                sq_last;
  b3cp_pkg::pos_t      sq_px, sq_py;
  b3cp_pkg::dep_t      sq_zc;

  assign be = !o_v || m_tready;

  always_comb begin
    if (sq_g.rej_depth) begin
      sq_st = b3cp_pkg::ST_DEPTH;
    end else if (sq_g.rej_near) begin
      sq_st = b3cp_pkg::ST_NEAR;
    end else begin
      sq_st = b3cp_pkg::ST_OK;
    end
    sq_last = (sq_st != b3cp_pkg::ST_OK) || (sq_k == 3'd7);
    sq_px   = sq_g.xc[sq_k[1:0]];
    sq_zc   = sq_g.zc[sq_k[1:0]];
    sq_py   = sq_k[2] ? sq_g.ycam - $signed({19'b0, sq_g.half_h})
                      : sq_g.ycam + $signed({19'b0, sq_g.half_h});
  end

  assign take = !sq_v || (be && sq_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
      sq_k <= '0;
    end else if (take) begin
      sq_v <= f_valid;
      sq_k <= '0;
    end else if (be) begin
      sq_k <= sq_k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && f_valid) begin
      sq_g <= f_geom;
    end
  end

  // -------- stage 1: partial products of the projection numerators
  logic               b1_v, b1_last;
  logic [2:0]         b1_idx;
  b3cp_pkg::status_e  b1_st;
  logic [40:0]        b1_flx, b1_fly;
  logic signed [41:0] b1_fhx, b1_fhy;
  logic signed [47:0] b1_czx, b1_czy;
  b3cp_pkg::dep_t     b1_zc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (be) begin
      b1_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      b1_idx  <= sq_k;
      b1_st   <= sq_st;
      b1_last <= sq_last;
      b1_zc   <= sq_zc;
      b1_flx  <= cfg.focal_x * sq_px[20:0];
      b1_fly  <= cfg.focal_y * sq_py[20:0];
      b1_fhx  <= $signed({1'b0, cfg.focal_x}) * $signed(sq_px[41:21]);
      b1_fhy  <= $signed({1'b0, cfg.focal_y}) * $signed(sq_py[41:21]);
      b1_czx  <= $signed({1'b0, cfg.centre_x}) * sq_zc;
      b1_czy  <= $signed({1'b0, cfg.centre_y}) * sq_zc;
    end
  end

  // -------- stage 2: full numerators
  logic               b2_v, b2_last;
  logic [2:0]         b2_idx;
  b3cp_pkg::status_e  b2_st;
  logic signed [63:0] b2_nx, b2_ny;
  b3cp_pkg::dep_t     b2_zc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_v <= 1'b0;
    end else if (be) begin
      b2_v <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      b2_idx  <= b1_idx;
      b2_st   <= b1_st;
      b2_last <= b1_last;
      b2_zc   <= b1_zc;
      b2_nx   <= (64'(b1_fhx) <<< 21) + $signed({23'b0, b1_flx}) + 64'(b1_czx);
      b2_ny   <= (64'(b1_fhy) <<< 21) + $signed({23'b0, b1_fly}) + 64'(b1_czy);
    end
  end

  // -------- stage 3: magnitude plus half divisor for rounding
  logic              b3_v, b3_sy;
  logic [63:0]       b3_nx, b3_ny;
  logic [30:0]       b3_den;
  logic [7:0]        b3_side;
  logic [63:0]       magx, magy;

  always_comb begin
    magx = b2_nx[63] ? 64'(-b2_nx) : 64'(b2_nx);
    magy = b2_ny[63] ? 64'(-b2_ny) : 64'(b2_ny);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_v <= 1'b0;
    end else if (be) begin
      b3_v <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      b3_nx   <= magx + {34'b0, b2_zc[26:0], 3'b0};
      b3_ny   <= magy + {34'b0, b2_zc[26:0], 3'b0};
      b3_den  <= {b2_zc[26:0], 4'b0};
      b3_side <= {b2_idx, b2_st, b2_last, b2_nx[63], 1'b0};
      b3_sy   <= b2_ny[63];
    end
  end

  // -------- projection dividers
  logic        px_v, py_v, ovx, ovy, dy_s;
  logic [15:0] qx, qy;
  logic [7:0]  dx_s;

  b3cp_div #(.NW(64), .DW(31), .QB(16), .SW(8)) u_div_px (
    .clk(clk), .rst(rst), .en(be), .vi(b3_v), .n(b3_nx), .d(b3_den),
    .side(b3_side), .vo(px_v), .q(qx), .ovf(ovx), .side_o(dx_s)
  );

  b3cp_div #(.NW(64), .DW(31), .QB(16), .SW(1)) u_div_py (
    .clk(clk), .rst(rst), .en(be), .vi(b3_v), .n(b3_ny), .d(b3_den),
    .side(b3_sy), .vo(py_v), .q(qy), .ovf(ovy), .side_o(dy_s)
  );

  // -------- output register: saturate and format
  logic [15:0] cx_c, cy_c;
  logic [1:0]  st_c;

  always_comb begin
    st_c = dx_s[4:3];
    if (dx_s[1]) begin
      cx_c = (ovx || (qx > 16'd32768)) ? 16'h8000 : 16'(-qx);
    end else begin
      cx_c = (ovx || qx[15]) ? 16'h7fff : qx;
    end
    if (dy_s) begin
      cy_c = (ovy || (qy > 16'd32768)) ? 16'h8000 : 16'(-qy);
    end else begin
      cy_c = (ovy || qy[15]) ? 16'h7fff : qy;
    end
    if (st_c != b3cp_pkg::ST_OK) begin
      cx_c = '0;
      cy_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (be) begin
      o_v <= px_v && py_v;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      m_tdata <= {5'b0, cy_c, cx_c, dx_s[7:5]};
      m_tuser <= st_c;
      m_tlast <= dx_s[2];
    end
  end

  assign m_tvalid = o_v;

  // -------- checks
  a_reject_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != b3cp_pkg::ST_OK) |-> m_tlast && (m_tdata == '0))
    else $error("reject beat without tlast or with data");

  a_inner_is_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == b3cp_pkg::ST_OK)
    else $error("non-final beat carries reject status");

  a_seq_idle_count: assert property (@(posedge clk) disable iff (rst)
    !sq_v |-> sq_k == '0)
    else $error("corner counter running while sequencer empty");

endmodule

// ===== tb/tb_box3d_corner_projector_top.sv =====
// ---------------------------------------------------------------------------
// tb_box3d_corner_projector_top
// Self-checking testbench for the 3D box corner projector.
// ---------------------------------------------------------------------------
// A queue of detections feeds a clocked driver on the s_t* channel. Each
// accepted detection is run through an integer model of the unprojection,
// CORDIC rotation and pinhole projection. The model's corner or reject beats
// are queued and compared field by field with the m_t* beats. Both sides idle
// at random. Phases with different intrinsics and limits, the extremes among
// them, are written between bursts while the block is idle.
// ---------------------------------------------------------------------------
module tb_box3d_corner_projector_top;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [15:0]        spx;
    logic [15:0]        spy;
    logic [15:0]        dep;
    logic [15:0]        hgt;
    logic [15:0]        wid;
    logic [15:0]        len;
    logic signed [14:0] hdg;
  } detection_t;

  typedef struct {
    logic [2:0]         idx;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    b3cp_pkg::status_e  st;
    logic               last;
  } corner_beat_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [39:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [19:0]  cfg_data;

  // register copy used by the predictor
  longint fx_r, fy_r, cx_r, cy_r, near_r, far_r;

  detection_t   pending_dets[$];
  corner_beat_t expected_corners[$];
  int           errors;
  bit           burst_mode;

  box3d_corner_projector_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic longint div_round(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // heading Q.12 to sine/cosine Q.24 via 20-step rotation CORDIC
  task automatic heading_sin_cos(input longint a, output longint s, output longint c);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    x = longint'(b3cp_pkg::CORDIC_GAIN_Q24);
    y = 0;
    if (a > longint'(b3cp_pkg::PI_Q12)) a -= longint'(b3cp_pkg::TWO_PI_Q12);
    if (a < -longint'(b3cp_pkg::PI_Q12)) a += longint'(b3cp_pkg::TWO_PI_Q12);
    if (a > longint'(b3cp_pkg::HALF_PI_Q12)) begin
      a -= longint'(b3cp_pkg::PI_Q12);
      flip = 1'b1;
    end else if (a < -longint'(b3cp_pkg::HALF_PI_Q12)) begin
      a += longint'(b3cp_pkg::PI_Q12);
      flip = 1'b1;
    end
    z = a * 4096;
    for (int i = 0; i < b3cp_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(b3cp_pkg::ATAN_Q24[i]);
      end else begin
        x += dx; y -= dy; z += longint'(b3cp_pkg::ATAN_Q24[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint to_pixel(longint f, longint ctr, longint p, longint zc);
    return clamp(div_round(f * p + ctr * zc, zc * 16), -32768, 32767);
  endfunction

  task automatic push_reject(b3cp_pkg::status_e st);
    corner_beat_t b;
    b.idx = '0; b.cx = '0; b.cy = '0; b.st = st; b.last = 1'b1;
    expected_corners = {expected_corners, b};
  endtask

  // expected beats of one accepted detection
  task automatic predict_corners(detection_t det);
    longint d, u8, v8, xcam, ycam, zcam, hh, hl, hw, s, c, fxd, fyd;
    longint ox, oy, oz, xr, zr, xc, yc, zc;
    longint px[8], py[8];
    corner_beat_t b;
    int q;
    d = longint'(det.dep);
    if (d <= near_r || d > far_r) begin
      push_reject(b3cp_pkg::ST_DEPTH);
      return;
    end
    u8 = (2 * longint'(det.left) + longint'(det.spx)) * 8;
    v8 = (longint'(det.top) + longint'(det.spy)) * 16;
    fxd = (fx_r != 0) ? fx_r : 1;
    fyd = (fy_r != 0) ? fy_r : 1;
    xcam = clamp(div_round((u8 - cx_r) * d * 256, fxd), -(64'sd1 <<< 40), 64'sd1 <<< 40);
    ycam = clamp(div_round((v8 - cy_r) * d * 256, fyd), -(64'sd1 <<< 40), 64'sd1 <<< 40);
    hh = longint'(det.hgt) * 128;
    hl = longint'(det.len) * 128;
    hw = longint'(det.wid) * 128;
    ycam -= hh;
    zcam = d * 256;
    heading_sin_cos(longint'(det.hdg), s, c);
    for (int k = 0; k < 8; k++) begin
      q = k & 3;
      ox = (q == 0 || q == 3) ? -hl : hl;
      oz = (q < 2) ? -hw : hw;
      oy = (k < 4) ? hh : -hh;
      xr = div_round(ox * c + oz * s, 64'sd1 <<< 24);
      zr = div_round(oz * c - ox * s, 64'sd1 <<< 24);
      xc = xr + xcam;
      yc = oy + ycam;
      zc = zr + zcam;
      if (zc <= near_r * 256) begin
        push_reject(b3cp_pkg::ST_NEAR);
        return;
      end
      px[k] = to_pixel(fx_r, cx_r, xc, zc);
      py[k] = to_pixel(fy_r, cy_r, yc, zc);
    end
    for (int k = 0; k < 8; k++) begin
      b.idx = 3'(k);
      b.cx = px[k][15:0];
      b.cy = py[k][15:0];
      b.st = b3cp_pkg::ST_OK;
      b.last = (k == 7);
      expected_corners = {expected_corners, b};
    end
  endtask

  // ---------------------------------------------------------------- driver
  int         send_gap;
  detection_t cur_det;
  logic       nxt_valid;

  function automatic int draw_wait();
    return burst_mode ? 0 : int'($urandom_range(0, 19));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      send_gap = 0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_corners(cur_det);
        nxt_valid = 1'b0;
        send_gap = draw_wait();
      end else if (!s_tvalid && send_gap > 0) begin
        send_gap--;
      end
      if (!nxt_valid && send_gap == 0 && pending_dets.size() > 0) begin
        cur_det = pending_dets.pop_front();
        s_tdata <= {1'b0, cur_det.hdg, cur_det.len, cur_det.wid, cur_det.hgt,
                    cur_det.dep, cur_det.spy, cur_det.spx, cur_det.top, cur_det.left};
        nxt_valid = 1'b1;
      end
      s_tvalid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------- monitor
  int           recv_stall;
  corner_beat_t exp_b;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_corners.size() == 0) begin
          $error("unexpected result beat: tdata %h tuser %0d", m_tdata, m_tuser);
          errors++;
        end else begin
          exp_b = expected_corners.pop_front();
          if (m_tdata[2:0] !== exp_b.idx) begin
            $error("corner_index: expected %0d, got %0d", exp_b.idx, m_tdata[2:0]);
            errors++;
          end
          if (m_tdata[18:3] !== exp_b.cx) begin
            $error("corner_x: expected %0d, got %0d", exp_b.cx, $signed(m_tdata[18:3]));
            errors++;
          end
          if (m_tdata[34:19] !== exp_b.cy) begin
            $error("corner_y: expected %0d, got %0d", exp_b.cy, $signed(m_tdata[34:19]));
            errors++;
          end
          if (m_tuser !== exp_b.st) begin
            $error("status: expected %0d, got %0d", exp_b.st, m_tuser);
            errors++;
          end
          if (m_tlast !== exp_b.last) begin
            $error("last: expected %0d, got %0d", exp_b.last, m_tlast);
            errors++;
          end
        end
        recv_stall = draw_wait();
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_tready <= (recv_stall == 0);
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(b3cp_pkg::reg_idx_e idx, longint val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[19:0];
    case (idx)
      b3cp_pkg::REG_FOCAL_X:    fx_r   = val & 20'hFFFFF;
      b3cp_pkg::REG_FOCAL_Y:    fy_r   = val & 20'hFFFFF;
      b3cp_pkg::REG_CENTRE_X:   cx_r   = val & 20'hFFFFF;
      b3cp_pkg::REG_CENTRE_Y:   cy_r   = val & 20'hFFFFF;
      b3cp_pkg::REG_NEAR_LIMIT: near_r = val & 16'hFFFF;
      b3cp_pkg::REG_FAR_LIMIT:  far_r  = val & 16'hFFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(longint fx, longint fy, longint cx, longint cy,
                           longint nr, longint fr);
    write_reg(b3cp_pkg::REG_FOCAL_X, fx);
    write_reg(b3cp_pkg::REG_FOCAL_Y, fy);
    write_reg(b3cp_pkg::REG_CENTRE_X, cx);
    write_reg(b3cp_pkg::REG_CENTRE_Y, cy);
    write_reg(b3cp_pkg::REG_NEAR_LIMIT, nr);
    write_reg(b3cp_pkg::REG_FAR_LIMIT, fr);
  endtask

  // block until every queued beat has gone out and come back, then settle
  task automatic drain();
    while (pending_dets.size() != 0 || s_tvalid || expected_corners.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic add_det(detection_t det);
    pending_dets = {pending_dets, det};
  endtask

  function automatic detection_t make_det(int l, int t, int sx, int sy, int d,
                                          int h, int w, int ln, int hd);
    detection_t det;
    det.left = 16'(l); det.top = 16'(t); det.spx = 16'(sx); det.spy = 16'(sy);
    det.dep = 16'(d); det.hgt = 16'(h); det.wid = 16'(w); det.len = 16'(ln);
    det.hdg = 15'(hd);
    return det;
  endfunction

  // mostly plausible boxes in front of the camera, some raw noise
  function automatic detection_t rand_det();
    detection_t det;
    int lo, hi;
    det.left = 16'($urandom); det.top = 16'($urandom);
    det.spx = 16'($urandom); det.spy = 16'($urandom);
    det.dep = 16'($urandom); det.hgt = 16'($urandom);
    det.wid = 16'($urandom); det.len = 16'($urandom);
    det.hdg = 15'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      lo = int'(near_r) + 1;
      hi = int'(far_r);
      if (lo <= hi) det.dep = 16'($urandom_range(lo, hi));
      det.left = 16'($urandom_range(0, 20000));
      det.top  = 16'($urandom_range(0, 6000));
      det.spx  = 16'($urandom_range(0, 4000));
      det.spy  = 16'($urandom_range(0, 4000));
      det.hgt  = 16'($urandom_range(0, 1200));
      det.wid  = 16'($urandom_range(0, 800));
      det.len  = 16'($urandom_range(0, 1500));
      if ($urandom_range(0, 3) == 0) det.hdg = 15'(int'($urandom_range(0, 25736)) - 12868);
    end
    return det;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) add_det(rand_det());
    drain();
  endtask

  initial begin
    errors = 0;
    burst_mode = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = b3cp_pkg::REG_FOCAL_X;
    cfg_data = '0;
    fx_r = 70477; fy_r = 125172; cx_r = 77460; cy_r = 77079; near_r = 26; far_r = 38400;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, depth limits, heading wrap and folds
    add_det(make_det(4800, 3000, 800, 600, 2560, 400, 450, 1100, 0));
    add_det(make_det(4800, 3000, 800, 600, 26, 400, 450, 1100, 0));
    add_det(make_det(4800, 3000, 800, 600, 27, 0, 0, 0, 0));
    add_det(make_det(4800, 3000, 800, 600, 38400, 400, 450, 1100, 100));
    add_det(make_det(4800, 3000, 800, 600, 38401, 400, 450, 1100, 0));
    add_det(make_det(4800, 3000, 800, 600, 0, 400, 450, 1100, 0));
    add_det(make_det(4800, 3000, 800, 600, 65535, 400, 450, 1100, 0));
    add_det(make_det(4800, 3000, 800, 600, 2560, 400, 450, 1100, 12868));
    add_det(make_det(4800, 3000, 800, 600, 2560, 400, 450, 1100, -12868));
    add_det(make_det(4800, 3000, 800, 600, 2560, 400, 450, 1100, 6434));
    add_det(make_det(4800, 3000, 800, 600, 2560, 400, 450, 1100, -6435));
    add_det(make_det(4800, 3000, 800, 600, 2560, 400, 450, 1100, 16383));
    add_det(make_det(4800, 3000, 800, 600, 2560, 400, 450, 1100, -16384));
    add_det(make_det(-32768, -32768, 0, 0, 5000, 300, 300, 300, 2000));
    add_det(make_det(32767, 32767, 65535, 65535, 5000, 300, 300, 300, -2000));
    add_det(make_det(4800, 3000, 800, 600, 2560, 65535, 65535, 65535, 0));
    add_det(make_det(4800, 3000, 800, 600, 30000, 65535, 0, 0, 800));
    add_det(make_det(0, 0, 0, 0, 38400, 2000, 200, 200, 0));
    add_det(make_det(4800, 3000, 800, 600, 300, 100, 200, 600, 3000));
    add_det(make_det(-1, -1, 1, 1, 27, 1, 1, 1, -1));
    drain();
    run_random(25);

    // extreme intrinsics, no idling
    burst_mode = 1'b1;
    write_all(1048575, 1048575, 0, 0, 0, 65535);
    run_random(40);
    burst_mode = 1'b0;

    // zero focal lengths, maximal principal point
    write_all(0, 0, 1048575, 1048575, 1, 65535);
    run_random(40);

    // near above far: everything rejected on depth
    write_all(70000, 70000, 80000, 80000, 65535, 0);
    run_random(15);

    // random plausible intrinsics
    for (int p = 0; p < 4; p++) begin
      burst_mode = (p == 2);
      write_all(longint'($urandom_range(20000, 400000)),
                longint'($urandom_range(20000, 400000)),
                longint'($urandom_range(0, 300000)), longint'($urandom_range(0, 200000)),
                longint'($urandom_range(0, 600)), longint'($urandom_range(10000, 65535)));
      run_random(35);
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
